### hw/rtl/sdspi_pkg.sv
// Shared types and constants for the SD card SPI-mode init and block read core.
package sdspi_pkg;

    localparam int BLOCK_BYTES = 512;

    localparam logic [15:0] POLL_LIMIT_RST   = 16'd2000;
    localparam logic [7:0]  REPLY_TRIES_RST  = 8'd8;
    localparam logic [7:0]  WAKEUP_BYTES_RST = 8'd10;

    localparam logic [7:0] CMD0   = 8'h40;
    localparam logic [7:0] CMD8   = 8'h48;
    localparam logic [7:0] CMD55  = 8'h77;
    localparam logic [7:0] ACMD41 = 8'h69;
    localparam logic [7:0] CMD58  = 8'h7A;
    localparam logic [7:0] CMD16  = 8'h50;
    localparam logic [7:0] CMD17  = 8'h51;

    localparam logic [7:0]  CRC_CMD0   = 8'h95;
    localparam logic [7:0]  CRC_CMD8   = 8'h87;
    localparam logic [7:0]  CRC_NONE   = 8'hFF;
    localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
    localparam logic [31:0] ARG_ACMD41 = 32'h4000_0000;
    localparam logic [7:0]  IDLE_BYTE  = 8'hFF;
    localparam logic [7:0]  TOKEN_BYTE = 8'hFE;
    localparam logic [7:0]  R1_IDLE    = 8'h01;
    localparam logic [7:0]  R7_PATTERN = 8'hAA;

    typedef enum logic [1:0] {
        CFG_POLL_LIMIT   = 2'd0,
        CFG_REPLY_TRIES  = 2'd1,
        CFG_WAKEUP_BYTES = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_INIT = 2'd0,
        OP_READ = 2'd1,
        OP_XCHG = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_CARD = 2'd1,
        ST_FAIL    = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        P_IDLE,
        P_WAKE,
        P_FRAME,
        P_REPLY,
        P_R7,
        P_OCR,
        P_TOKEN,
        P_DATA,
        P_CRC
    } t_phase;

    typedef struct packed {
        logic [15:0] poll_limit;
        logic [7:0]  reply_tries;
        logic [7:0]  wakeup_bytes;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [47:0] frame_shift;
        logic [15:0] byte_count;
        logic [7:0]  try_count;
        logic [7:0]  reply_save;
        logic        echo_ok;
        logic        card_ready;
        logic        card_block_addressed;
    } t_state;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        select;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        last;
        logic        done_res;
        logic [1:0]  status;
        logic        high_capacity;
    } t_result;

endpackage

### hw/rtl/sd_spi_init_and_block_read_core.sv
// SD card SPI-mode init and single block read sequencer, top level.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_opcode, i_sector, i_rx_byte
//  out      output     o_out_valid / i_out_ready o_tx_* , o_data_*, o_last, o_done_res,
//                                                o_status, o_high_capacity
//  cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One transfer in per cycle while o_in_ready is high; its result is registered into the output queue.
// The sequencer step is one pass of combinational logic from the state registers.
// Results go through a two-entry output queue, so input is taken while one result waits.
// o_in_ready drops only with both queue entries full.
// Synchronous active-low reset returns to idle, card not ready, with default limits.
module sd_spi_init_and_block_read_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_sector,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_select,
    output logic        o_data_valid,
    output logic [7:0]  o_data_byte,
    output logic        o_last,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    output logic        o_high_capacity,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    sdspi_pkg::t_cfg    r_cfg;
    sdspi_pkg::t_state  r_state;
    sdspi_pkg::t_state  n_state;
    sdspi_pkg::t_result n_res;
    sdspi_pkg::t_result r_res0;
    sdspi_pkg::t_result r_res1;
    logic [1:0]         r_count;
    logic               push;
    logic               pop;

    sdspi_step u_step (
        .i_state   (r_state),
        .i_cfg     (r_cfg),
        .i_opcode  (i_opcode),
        .i_sector  (i_sector),
        .i_rx_byte (i_rx_byte),
        .o_state   (n_state),
        .o_result  (n_res)
    );

    assign o_in_ready  = (r_count != 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign push        = i_in_valid & o_in_ready;
    assign pop         = o_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_limit   <= sdspi_pkg::POLL_LIMIT_RST;
            r_cfg.reply_tries  <= sdspi_pkg::REPLY_TRIES_RST;
            r_cfg.wakeup_bytes <= sdspi_pkg::WAKEUP_BYTES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sdspi_pkg::CFG_POLL_LIMIT:   r_cfg.poll_limit   <= i_cfg_data;
                sdspi_pkg::CFG_REPLY_TRIES:  r_cfg.reply_tries  <= i_cfg_data[7:0];
                sdspi_pkg::CFG_WAKEUP_BYTES: r_cfg.wakeup_bytes <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // all-zero state is idle phase with every counter and flag clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (push) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            case (r_count)
                2'd0: begin
                    if (push) begin
                        r_res0  <= n_res;
                        r_count <= 2'd1;
                    end
                end
                2'd1: begin
                    if (push && pop) begin
                        r_res0 <= n_res;
                    end else if (push) begin
                        r_res1  <= n_res;
                        r_count <= 2'd2;
                    end else if (pop) begin
                        r_count <= 2'd0;
                    end
                end
                default: begin
                    if (pop) begin
                        r_res0  <= r_res1;
                        r_count <= 2'd1;
                    end
                end
            endcase
        end
    end

    assign o_tx_valid      = r_res0.tx_valid;
    assign o_tx_byte       = r_res0.tx_byte;
    assign o_select        = r_res0.select;
    assign o_data_valid    = r_res0.data_valid;
    assign o_data_byte     = r_res0.data_byte;
    assign o_last          = r_res0.last;
    assign o_done_res      = r_res0.done_res;
    assign o_status        = r_res0.status;
    assign o_high_capacity = r_res0.high_capacity;

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_out_valid)
        else $error("accepted transfer produced no result");

    a_done_excludes_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_done_res && o_tx_valid))
        else $error("done and tx byte in one result");

    a_last_with_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_data_valid)
        else $error("last without data byte");

    a_deselect_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tx_valid && !o_select |-> o_tx_byte == sdspi_pkg::IDLE_BYTE)
        else $error("non-idle byte sent with select low");

endmodule

### hw/rtl/sdspi_step.sv
// Combinational sequencer step: next state and result for one transfer.
module sdspi_step (
    input  sdspi_pkg::t_state  i_state,
    input  sdspi_pkg::t_cfg    i_cfg,
    input  logic [1:0]         i_opcode,
    input  logic [31:0]        i_sector,
    input  logic [7:0]         i_rx_byte,
    output sdspi_pkg::t_state  o_state,
    output sdspi_pkg::t_result o_result
);

    typedef struct packed {
        logic       emit;
        logic [7:0] tx_byte;
        logic       select;
        logic       fin;
        logic [1:0] status;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       last;
    } t_action;

    sdspi_pkg::t_state n_st;
    t_action           act;
    logic              do_r1;
    logic [7:0]        r1;
    logic              do_start;
    logic [7:0]        s_cmd;
    logic [31:0]       s_arg;
    logic [7:0]        s_crc;
    logic [7:0]        frame_byte;
    logic [31:0]       read_addr;

    assign read_addr = i_state.card_block_addressed ? i_sector
                     : 32'(i_sector * 32'(sdspi_pkg::BLOCK_BYTES));

    // next state
    always_comb begin
        n_st       = i_state;
        act        = '0;
        do_r1      = 1'b0;
        r1         = sdspi_pkg::IDLE_BYTE;
        do_start   = 1'b0;
        s_cmd      = sdspi_pkg::CMD0;
        s_arg      = '0;
        s_crc      = sdspi_pkg::CRC_NONE;
        frame_byte = '0;

        case (i_opcode)
            sdspi_pkg::OP_INIT: begin
                if (i_state.card_ready) begin
                    act.fin    = 1'b1;
                    act.status = sdspi_pkg::ST_OK;
                    n_st.phase = sdspi_pkg::P_IDLE;
                end else begin
                    n_st.card_block_addressed = 1'b0;
                    n_st.phase      = sdspi_pkg::P_WAKE;
                    n_st.byte_count = '0;
                    if (i_cfg.wakeup_bytes == 8'd0) begin
                        do_start = 1'b1;
                        s_cmd    = sdspi_pkg::CMD0;
                        s_crc    = sdspi_pkg::CRC_CMD0;
                    end else begin
                        act.emit    = 1'b1;
                        act.tx_byte = sdspi_pkg::IDLE_BYTE;
                        act.select  = 1'b0;
                    end
                end
            end
            sdspi_pkg::OP_READ: begin
                if (!i_state.card_ready) begin
                    act.fin    = 1'b1;
                    act.status = sdspi_pkg::ST_FAIL;
                    n_st.phase = sdspi_pkg::P_IDLE;
                end else begin
                    do_start = 1'b1;
                    s_cmd    = sdspi_pkg::CMD17;
                    s_arg    = read_addr;
                end
            end
            sdspi_pkg::OP_XCHG: begin
                case (i_state.phase)
                    sdspi_pkg::P_WAKE: begin
                        n_st.byte_count = i_state.byte_count + 16'd1;
                        if (n_st.byte_count >= {8'd0, i_cfg.wakeup_bytes}) begin
                            do_start = 1'b1;
                            s_cmd    = sdspi_pkg::CMD0;
                            s_crc    = sdspi_pkg::CRC_CMD0;
                        end else begin
                            act.emit    = 1'b1;
                            act.tx_byte = sdspi_pkg::IDLE_BYTE;
                            act.select  = 1'b0;
                        end
                    end
                    sdspi_pkg::P_FRAME: begin
                        n_st.try_count = i_state.try_count + 8'd1;
                        if (n_st.try_count <= 8'd6) begin
                            case (n_st.try_count[2:0])
                                3'd1:    frame_byte = i_state.frame_shift[47:40];
                                3'd2:    frame_byte = i_state.frame_shift[39:32];
                                3'd3:    frame_byte = i_state.frame_shift[31:24];
                                3'd4:    frame_byte = i_state.frame_shift[23:16];
                                3'd5:    frame_byte = i_state.frame_shift[15:8];
                                default: frame_byte = i_state.frame_shift[7:0];
                            endcase
                            act.emit    = 1'b1;
                            act.tx_byte = frame_byte;
                            act.select  = 1'b1;
                        end else begin
                            n_st.phase     = sdspi_pkg::P_REPLY;
                            n_st.try_count = '0;
                            if (i_cfg.reply_tries == 8'd0) begin
                                do_r1 = 1'b1;
                            end else begin
                                act.emit    = 1'b1;
                                act.tx_byte = sdspi_pkg::IDLE_BYTE;
                                act.select  = 1'b1;
                            end
                        end
                    end
                    sdspi_pkg::P_REPLY: begin
                        n_st.try_count = i_state.try_count + 8'd1;
                        if (!i_rx_byte[7]) begin
                            do_r1 = 1'b1;
                            r1    = i_rx_byte;
                        end else if (n_st.try_count >= i_cfg.reply_tries) begin
                            do_r1 = 1'b1;
                        end else begin
                            act.emit    = 1'b1;
                            act.tx_byte = sdspi_pkg::IDLE_BYTE;
                            act.select  = 1'b1;
                        end
                    end
                    sdspi_pkg::P_R7: begin
                        if (i_state.try_count == 8'd2) begin
                            n_st.echo_ok = (i_rx_byte == sdspi_pkg::R1_IDLE);
                        end
                        n_st.try_count = i_state.try_count + 8'd1;
                        if (n_st.try_count >= 8'd4) begin
                            if (!n_st.echo_ok || i_rx_byte != sdspi_pkg::R7_PATTERN) begin
                                act.fin    = 1'b1;
                                act.status = sdspi_pkg::ST_FAIL;
                                n_st.phase = sdspi_pkg::P_IDLE;
                            end else begin
                                n_st.byte_count = '0;
                                do_start = 1'b1;
                                s_cmd    = sdspi_pkg::CMD55;
                            end
                        end else begin
                            act.emit    = 1'b1;
                            act.tx_byte = sdspi_pkg::IDLE_BYTE;
                            act.select  = 1'b1;
                        end
                    end
                    sdspi_pkg::P_OCR: begin
                        if (i_state.try_count == 8'd0) begin
                            n_st.reply_save = i_rx_byte;
                        end
                        n_st.try_count = i_state.try_count + 8'd1;
                        if (n_st.try_count >= 8'd4) begin
                            n_st.card_block_addressed = n_st.reply_save[6];
                            if (!n_st.reply_save[6]) begin
                                do_start = 1'b1;
                                s_cmd    = sdspi_pkg::CMD16;
                                s_arg    = 32'(sdspi_pkg::BLOCK_BYTES);
                            end else begin
                                n_st.card_ready = 1'b1;
                                act.fin    = 1'b1;
                                act.status = sdspi_pkg::ST_OK;
                                n_st.phase = sdspi_pkg::P_IDLE;
                            end
                        end else begin
                            act.emit    = 1'b1;
                            act.tx_byte = sdspi_pkg::IDLE_BYTE;
                            act.select  = 1'b1;
                        end
                    end
                    sdspi_pkg::P_TOKEN: begin
                        n_st.byte_count = i_state.byte_count + 16'd1;
                        if (i_rx_byte == sdspi_pkg::TOKEN_BYTE) begin
                            n_st.phase      = sdspi_pkg::P_DATA;
                            n_st.byte_count = '0;
                            act.emit    = 1'b1;
                            act.tx_byte = sdspi_pkg::IDLE_BYTE;
                            act.select  = 1'b1;
                        end else if (n_st.byte_count >= i_cfg.poll_limit) begin
                            act.fin    = 1'b1;
                            act.status = sdspi_pkg::ST_FAIL;
                            n_st.phase = sdspi_pkg::P_IDLE;
                        end else begin
                            act.emit    = 1'b1;
                            act.tx_byte = sdspi_pkg::IDLE_BYTE;
                            act.select  = 1'b1;
                        end
                    end
                    sdspi_pkg::P_DATA: begin
                        act.data_valid  = 1'b1;
                        act.data_byte   = i_rx_byte;
                        n_st.byte_count = i_state.byte_count + 16'd1;
                        if (n_st.byte_count >= 16'(sdspi_pkg::BLOCK_BYTES)) begin
                            act.last       = 1'b1;
                            n_st.phase     = sdspi_pkg::P_CRC;
                            n_st.try_count = '0;
                        end
                        act.emit    = 1'b1;
                        act.tx_byte = sdspi_pkg::IDLE_BYTE;
                        act.select  = 1'b1;
                    end
                    sdspi_pkg::P_CRC: begin
                        n_st.try_count = i_state.try_count + 8'd1;
                        if (n_st.try_count >= 8'd2) begin
                            act.fin    = 1'b1;
                            act.status = sdspi_pkg::ST_OK;
                            n_st.phase = sdspi_pkg::P_IDLE;
                        end else begin
                            act.emit    = 1'b1;
                            act.tx_byte = sdspi_pkg::IDLE_BYTE;
                            act.select  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        // R1 reply handling, keyed on the command in flight
        if (do_r1) begin
            case (i_state.frame_shift[47:40])
                sdspi_pkg::CMD0: begin
                    if (r1 != sdspi_pkg::R1_IDLE) begin
                        act.fin    = 1'b1;
                        act.status = sdspi_pkg::ST_NO_CARD;
                        n_st.phase = sdspi_pkg::P_IDLE;
                    end else begin
                        do_start = 1'b1;
                        s_cmd    = sdspi_pkg::CMD8;
                        s_arg    = sdspi_pkg::ARG_CMD8;
                        s_crc    = sdspi_pkg::CRC_CMD8;
                    end
                end
                sdspi_pkg::CMD8: begin
                    if (!r1[2]) begin
                        n_st.phase     = sdspi_pkg::P_R7;
                        n_st.try_count = '0;
                        n_st.echo_ok   = 1'b0;
                        act.emit    = 1'b1;
                        act.tx_byte = sdspi_pkg::IDLE_BYTE;
                        act.select  = 1'b1;
                    end else begin
                        n_st.byte_count = '0;
                        do_start = 1'b1;
                        s_cmd    = sdspi_pkg::CMD55;
                    end
                end
                sdspi_pkg::CMD55: begin
                    do_start = 1'b1;
                    s_cmd    = sdspi_pkg::ACMD41;
                    s_arg    = sdspi_pkg::ARG_ACMD41;
                end
                sdspi_pkg::ACMD41: begin
                    n_st.byte_count = i_state.byte_count + 16'd1;
                    if (r1 == 8'd0) begin
                        do_start = 1'b1;
                        s_cmd    = sdspi_pkg::CMD58;
                    end else if (n_st.byte_count >= i_cfg.poll_limit) begin
                        act.fin    = 1'b1;
                        act.status = sdspi_pkg::ST_FAIL;
                        n_st.phase = sdspi_pkg::P_IDLE;
                    end else begin
                        do_start = 1'b1;
                        s_cmd    = sdspi_pkg::CMD55;
                    end
                end
                sdspi_pkg::CMD58: begin
                    if (r1 == 8'd0) begin
                        n_st.phase     = sdspi_pkg::P_OCR;
                        n_st.try_count = '0;
                        act.emit    = 1'b1;
                        act.tx_byte = sdspi_pkg::IDLE_BYTE;
                        act.select  = 1'b1;
                    end else if (!i_state.card_block_addressed) begin
                        do_start = 1'b1;
                        s_cmd    = sdspi_pkg::CMD16;
                        s_arg    = 32'(sdspi_pkg::BLOCK_BYTES);
                    end else begin
                        n_st.card_ready = 1'b1;
                        act.fin    = 1'b1;
                        act.status = sdspi_pkg::ST_OK;
                        n_st.phase = sdspi_pkg::P_IDLE;
                    end
                end
                sdspi_pkg::CMD16: begin
                    act.fin    = 1'b1;
                    n_st.phase = sdspi_pkg::P_IDLE;
                    if (r1 != 8'd0) begin
                        act.status = sdspi_pkg::ST_FAIL;
                    end else begin
                        act.status      = sdspi_pkg::ST_OK;
                        n_st.card_ready = 1'b1;
                    end
                end
                sdspi_pkg::CMD17: begin
                    if (r1 != 8'd0) begin
                        act.fin    = 1'b1;
                        act.status = sdspi_pkg::ST_FAIL;
                        n_st.phase = sdspi_pkg::P_IDLE;
                    end else begin
                        n_st.phase      = sdspi_pkg::P_TOKEN;
                        n_st.byte_count = '0;
                        act.emit    = 1'b1;
                        act.tx_byte = sdspi_pkg::IDLE_BYTE;
                        act.select  = 1'b1;
                    end
                end
                default: begin
                    act.fin    = 1'b1;
                    act.status = sdspi_pkg::ST_FAIL;
                    n_st.phase = sdspi_pkg::P_IDLE;
                end
            endcase
        end

        // command launch: leading idle byte, then six frame bytes
        if (do_start) begin
            n_st.frame_shift = {s_cmd, s_arg, s_crc};
            n_st.phase       = sdspi_pkg::P_FRAME;
            n_st.try_count   = '0;
            act.emit    = 1'b1;
            act.tx_byte = sdspi_pkg::IDLE_BYTE;
            act.select  = 1'b1;
        end
    end

    assign o_state = n_st;

    // outputs
    always_comb begin
        o_result               = '0;
        o_result.tx_valid      = act.emit;
        o_result.tx_byte       = act.emit ? act.tx_byte : 8'd0;
        o_result.select        = act.emit & act.select;
        o_result.data_valid    = act.data_valid;
        o_result.data_byte     = act.data_valid ? act.data_byte : 8'd0;
        o_result.last          = act.last;
        o_result.done_res      = act.fin;
        o_result.status        = act.fin ? act.status : 2'd0;
        o_result.high_capacity = n_st.card_block_addressed;
    end

endmodule
